// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the positional list store RTL.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define PLS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// The expression must never be true at a clock edge outside reset.
`define PLS_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PLS_ASSERT(lbl, clk, rst, prop, msg)
`define PLS_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ----- rtl/core/pls_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the
// positional list store. Depends on nothing.
package pls_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = 7;
   localparam int OP_W   = 3;
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int ST_W   = 2;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_INSERT_AT  = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_POP_BACK   = 3'd4,
      OP_REMOVE_AT  = 3'd5
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_REMOVE = 2'd2
   } kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the request beat
      logic decide;     // latch status, target slot and starting pointer
      logic ins_read;   // read the slot below the pointer
      logic ins_write;  // move the read word up into the pointer slot
      logic ins_value;  // write the new value at the pointer, count up
      logic rem_read;   // read the pointer slot
      logic rem_grab;   // keep the read word as the removed value
      logic rem_write;  // move the read word down one slot
      logic count_dec;  // count down after a removal
      logic emit;       // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      kind_type kind;
      logic     ok;
      logic     ins_more;
      logic     rem_more;
      logic     out_free;
   } sts_type;

endpackage

// ----- rtl/core/positional_list_store.sv -----
// Top level of the positional list store: stream ports, field packing and
// the controller/datapath pair. Depends on pls_pkg, pls_ctrl, pls_datapath.
//
// Usage: each request beat on req_* carries an op code, a position and a
// value. The block keeps an ordered list of up to DEPTH (64) signed words
// and answers every request with one beat on rsp_*: the removed value (zero
// for insertions and failed requests), a status code (ok, full, empty, bad
// position) and the entry count after the request.
// A request is taken only while the block is idle. Status is latched in the
// decide step, and a rejected or unused request then goes from the dispatch
// step straight to the result step. An insertion moves the element at the
// target slot and each element above it up by one; a removal first reads
// out the element at the target slot, then moves each element above it
// down by one. Each moved element takes a read step and then a write step
// through the single write port. A result beat waits in an output register,
// so the block goes back to idle and takes the next request while the
// receiver stalls; it only holds in its final step if a second result is
// ready before the first is taken. Reset empties the list and drops any
// pending result.
// The entry memory needs no clearing pass: only slots below the count are
// ever read.

module positional_list_store
   import pls_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // op [2:0], position [9:3], value [41:10], zero padding [47:42]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // removed_value [31:0], status [33:32], entry_count [40:34],
   // zero padding [47:41]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int REQ_POS_LSB = OP_W;
   localparam int REQ_VAL_LSB = OP_W + POS_W;
   localparam int REQ_USED_W  = OP_W + POS_W + DATA_W;
   localparam int RSP_ST_LSB  = DATA_W;
   localparam int RSP_CNT_LSB = DATA_W + ST_W;
   localparam int RSP_USED_W  = DATA_W + ST_W + CNT_W;

   cmd_type           cmd;
   sts_type           sts;
   logic [OP_W-1:0]   req_op;
   logic [POS_W-1:0]  req_position;
   logic [DATA_W-1:0] req_value;
   logic [DATA_W-1:0] rsp_removed_value;
   logic [ST_W-1:0]   rsp_status;
   logic [CNT_W-1:0]  rsp_entry_count;
   logic [REQ_TDATA_W-REQ_USED_W-1:0] req_pad_unused;

   // Unpack the request beat; the padding bits carry nothing.
   assign req_op         = req_tdata[OP_W-1:0];
   assign req_position   = req_tdata[REQ_POS_LSB +: POS_W];
   assign req_value      = req_tdata[REQ_VAL_LSB +: DATA_W];
   assign req_pad_unused = req_tdata[REQ_TDATA_W-1:REQ_USED_W];

   pls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pls_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_op            (req_op),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count)
   );

   // Pack the result beat, padding the top bits with zeros.
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[DATA_W-1:0]            = rsp_removed_value;
      rsp_tdata[RSP_ST_LSB +: ST_W]    = rsp_status;
      rsp_tdata[RSP_CNT_LSB +: CNT_W]  = rsp_entry_count;
      rsp_tdata[RSP_TDATA_W-1:RSP_USED_W] = {(RSP_TDATA_W-RSP_USED_W){1'b0}}
         | {(RSP_TDATA_W-RSP_USED_W){1'b0 & (^req_pad_unused)}};
   end

endmodule

// ----- rtl/core/pls_datapath.sv -----
// Datapath of the positional list store: entry memory, count, pointer,
// request and result registers. Depends on pls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pls_datapath
   import pls_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [OP_W-1:0]     req_op,
   input  logic [POS_W-1:0]    req_position,
   input  logic [DATA_W-1:0]   req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DATA_W-1:0]   rsp_removed_value,
   output logic [ST_W-1:0]     rsp_status,
   output logic [CNT_W-1:0]    rsp_entry_count
);

   logic [DATA_W-1:0] mem [DEPTH];

   logic [OP_W-1:0]   op_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [DATA_W-1:0] val_ff;
   logic [DATA_W-1:0] got_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  ptr_ff;
   logic [CNT_W-1:0]  at_ff;
   status_type        st_ff;
   kind_type          kind_ff;

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_removed_ff;
   status_type        rsp_status_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   kind_type          kind_c;
   logic [CNT_W-1:0]  at_c;
   status_type        st_c;
   logic [CNT_W-1:0]  ptr_m1;
   logic [CNT_W-1:0]  rd_ptr;
   logic              wr_en;
   logic [CNT_W-1:0]  wr_ptr;
   logic [DATA_W-1:0] wr_data;

   assign ptr_m1 = ptr_ff - CNT_W'(1);

   // Decode the held request into its kind, target slot and status.
   always_comb begin
      kind_c = KIND_NONE;
      at_c   = '0;
      unique case (op_ff)
         OP_PUSH_FRONT: begin
            kind_c = KIND_INSERT;
            at_c   = '0;
         end
         OP_PUSH_BACK: begin
            kind_c = KIND_INSERT;
            at_c   = count_ff;
         end
         OP_INSERT_AT: begin
            kind_c = KIND_INSERT;
            at_c   = CNT_W'(pos_ff);
         end
         OP_POP_FRONT: begin
            kind_c = KIND_REMOVE;
            at_c   = '0;
         end
         OP_POP_BACK: begin
            kind_c = KIND_REMOVE;
            at_c   = count_ff - CNT_W'(1);
         end
         OP_REMOVE_AT: begin
            kind_c = KIND_REMOVE;
            at_c   = CNT_W'(pos_ff) - CNT_W'(1);
         end
         default: begin
            kind_c = KIND_NONE;
            at_c   = '0;
         end
      endcase

      st_c = ST_OK;
      if (kind_c == KIND_INSERT) begin
         if (count_ff == CNT_W'(DEPTH)) begin
            st_c = ST_FULL;
         end else if (at_c > count_ff) begin
            st_c = ST_RANGE;
         end
      end else if (kind_c == KIND_REMOVE) begin
         if (count_ff == '0) begin
            st_c = ST_EMPTY;
         end else if (op_ff == OP_REMOVE_AT && pos_ff == '0) begin
            st_c = ST_RANGE;
         end else if (at_c >= count_ff) begin
            st_c = ST_RANGE;
         end
      end
   end

   assign sts.kind     = kind_ff;
   assign sts.ok       = (st_ff == ST_OK);
   assign sts.ins_more = (ptr_ff > at_ff);
   assign sts.rem_more = (ptr_ff < count_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   // Single write port.
   always_comb begin
      wr_en   = cmd.ins_write || cmd.ins_value || cmd.rem_write;
      wr_ptr  = ptr_ff;
      wr_data = rd_data_ff;
      if (cmd.ins_value) begin
         wr_data = val_ff;
      end
      if (cmd.rem_write) begin
         wr_ptr = ptr_m1;
      end
   end

   assign rd_ptr = cmd.ins_read ? ptr_m1 : ptr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr[IDX_W-1:0]] <= wr_data;
      end
      if (cmd.ins_read || cmd.rem_read) begin
         rd_data_ff <= mem[rd_ptr[IDX_W-1:0]];
      end
   end

   // Request, decision (status, kind, target slot), pointer and removed-value registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         pos_ff <= req_position;
         val_ff <= req_value;
         got_ff <= '0;
      end
      if (cmd.decide) begin
         st_ff   <= st_c;
         kind_ff <= kind_c;
         at_ff   <= at_c;
         ptr_ff  <= (kind_c == KIND_INSERT) ? count_ff : at_c;
      end
      if (cmd.ins_write) begin
         ptr_ff <= ptr_m1;
      end
      if (cmd.rem_grab || cmd.rem_write) begin
         ptr_ff <= ptr_ff + CNT_W'(1);
      end
      if (cmd.rem_grab) begin
         got_ff <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.ins_value) begin
         count_ff <= count_ff + CNT_W'(1);
      end else if (cmd.count_dec) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   // Result register: holds one finished beat until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_removed_ff <= got_ff;
         rsp_status_ff  <= st_ff;
         rsp_count_ff   <= count_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_count   = rsp_count_ff;

   `PLS_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(DEPTH),
      "entry count above depth")
   `PLS_ASSERT(a_emit_free, clock, reset, cmd.emit |-> sts.out_free,
      "result emitted over an untaken beat")
   `PLS_ASSERT(a_fail_zero, clock, reset,
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_removed_ff == '0),
      "failed request carries a removed value")

endmodule

// ----- rtl/core/pls_ctrl.sv -----
// Controller of the positional list store: sequences decode, shifting and
// result hand-off. Depends on pls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pls_ctrl
   import pls_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_DISPATCH,
      S_INS_RD,
      S_INS_WR,
      S_REM_FIRST,
      S_REM_GOT,
      S_REM_RD,
      S_REM_WR,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      ready_in;
   logic      decided_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ready_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            ready_in = 1'b1;
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
               ready_in = 1'b0;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_DISPATCH;
         end
         // The decide step's outcome picks the loop on the following cycle.
         S_DISPATCH: begin
            if (sts.ok && sts.kind == KIND_INSERT) begin
               state_in = S_INS_RD;
            end else if (sts.ok && sts.kind == KIND_REMOVE) begin
               state_in = S_REM_FIRST;
            end else begin
               state_in = S_DONE;
            end
         end
         S_INS_RD: begin
            if (sts.ins_more) begin
               cmd.ins_read = 1'b1;
               state_in     = S_INS_WR;
            end else begin
               cmd.ins_value = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_INS_WR: begin
            cmd.ins_write = 1'b1;
            state_in      = S_INS_RD;
         end
         S_REM_FIRST: begin
            cmd.rem_read = 1'b1;
            state_in     = S_REM_GOT;
         end
         S_REM_GOT: begin
            cmd.rem_grab = 1'b1;
            state_in     = S_REM_RD;
         end
         S_REM_RD: begin
            if (sts.rem_more) begin
               cmd.rem_read = 1'b1;
               state_in     = S_REM_WR;
            end else begin
               cmd.count_dec = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_REM_WR: begin
            cmd.rem_write = 1'b1;
            state_in      = S_REM_RD;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, ready flag and a marker for the cycle after a decide step.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ready_ff   <= 1'b0;
         decided_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ready_ff   <= ready_in;
         decided_ff <= (state_ff == S_DECIDE);
      end
   end

   assign req_ready = ready_ff && (state_ff == S_IDLE);

   `PLS_ASSERT(a_ins_wr_src, clock, reset,
      (state_ff == S_INS_WR) |-> $past(sts.ins_more),
      "insert shift without a slot to move")
   `PLS_NEVER(a_load_busy, clock, reset, cmd.load && state_ff != S_IDLE,
      "request taken while busy")
   `PLS_NEVER(a_decide_done, clock, reset, decided_ff && state_ff == S_DECIDE,
      "decide step repeated")

endmodule

// ----- sim/tb_positional_list_store.sv -----
// Self-checking testbench for positional_list_store: stream requests in,
// predicted results compared beat by beat against the result stream.
// Depends on pls_pkg and the positional_list_store RTL.
module tb_positional_list_store;
   timeunit 1ns;
   timeprecision 1ps;
   import pls_pkg::*;

   // Op codes that the block leaves undecoded; it must answer them unchanged.
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
   // Extra wait at the end of the run, after every predicted result has arrived.
   localparam int DRAIN_CYCLES = 160;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [DATA_W-1:0] removed_value;
      status_type        status;
      logic [CNT_W-1:0]  entry_count;
   } list_outcome_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic [DATA_W-1:0] list_model[$];
   list_outcome_type  pending_results[$];
   int                mismatch_count = 0;
   int                result_index = 0;
   bit                idle_enabled = 1'b1;
   bit                filling = 1'b1;
   int                hold_request = 0;
   int                hold_left = 0;
   int                stall_left = 0;
   list_outcome_type  seen_result;
   list_outcome_type  want_result;

   positional_list_store uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #15_000_000;
      $display("tb_positional_list_store: FAIL");
      $finish;
   end

   // Applies one request to the list model and returns the result it gives.
   function automatic list_outcome_type apply_list_request(
         input logic [OP_W-1:0] op,
         input logic [POS_W-1:0] pos,
         input logic [DATA_W-1:0] val);
      list_outcome_type r;
      int               size;
      int               slot;
      r.removed_value = '0;
      r.status = ST_OK;
      size = list_model.size();
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
            if (op == OP_PUSH_FRONT) slot = 0;
            else if (op == OP_PUSH_BACK) slot = size;
            else slot = int'(pos);
            // A full store is reported ahead of a bad position.
            if (size >= DEPTH) r.status = ST_FULL;
            else if (slot > size) r.status = ST_RANGE;
            else list_model.insert(slot, val);
         end
         OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT: begin
            // Slot is 1-based here, matching the remove position field.
            if (op == OP_POP_FRONT) slot = 1;
            else if (op == OP_POP_BACK) slot = size;
            else slot = int'(pos);
            if (size == 0) r.status = ST_EMPTY;
            else if (slot == 0 || slot > size) r.status = ST_RANGE;
            else begin
               r.removed_value = list_model[slot-1];
               list_model.delete(slot-1);
            end
         end
         default: ;
      endcase
      r.entry_count = CNT_W'(list_model.size());
      return r;
   endfunction

   // Offers one request beat, with an optional random gap ahead of it, and
   // records the expected result once the beat is taken. The valid is left
   // high so that a following beat can be offered without a gap.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] val);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - DATA_W - POS_W - OP_W){1'b0}}, val, pos, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(apply_list_request(op, pos, val));
   endtask

   // Random request whose mix drifts between filling and draining, so that
   // the count sweeps from empty to full and back again and again.
   task automatic send_random_request();
      logic [OP_W-1:0]   op;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] val;
      int                size;
      int                pick;
      size = list_model.size();
      if (size == DEPTH && $urandom_range(0, 5) == 0) filling = 1'b0;
      else if (size == 0 && $urandom_range(0, 5) == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) == 0) filling = !filling;
      pick = $urandom_range(0, 99);
      if (pick < 3) op = $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
      else if ((pick < 78) == filling)
         op = OP_W'($urandom_range(int'(OP_PUSH_FRONT), int'(OP_INSERT_AT)));
      else
         op = OP_W'($urandom_range(int'(OP_POP_FRONT), int'(OP_REMOVE_AT)));
      if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, DEPTH));
      else if (op == OP_REMOVE_AT) pos = (size == 0) ? '0 : POS_W'($urandom_range(1, size));
      else pos = POS_W'($urandom_range(0, size));
      case ($urandom_range(0, 11))
         0: val = 32'h8000_0000;
         1: val = 32'h7FFF_FFFF;
         2: val = 32'hFFFF_FFFF;
         3: val = 32'h0000_0000;
         default: val = $urandom;
      endcase
      send_request(op, pos, val);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_and_unused_ops();
      send_request(OP_POP_FRONT, 7'd0, $urandom);
      send_request(OP_POP_BACK, 7'd0, $urandom);
      send_request(OP_REMOVE_AT, 7'd1, $urandom);
      // Empty is reported ahead of the bad position.
      send_request(OP_REMOVE_AT, 7'd0, $urandom);
      send_request(OP_UNUSED_LO, 7'd3, $urandom);
      send_request(OP_UNUSED_HI, 7'd64, $urandom);
      send_request(OP_INSERT_AT, 7'd1, $urandom);
      send_request(OP_INSERT_AT, 7'd64, $urandom);
   endtask

   task automatic test_positional_edges();
      send_request(OP_INSERT_AT, 7'd0, 32'h7FFF_FFFF);
      send_request(OP_PUSH_BACK, 7'd0, 32'h8000_0000);
      send_request(OP_PUSH_FRONT, 7'd127, 32'h0000_0000);
      send_request(OP_INSERT_AT, 7'd3, 32'hFFFF_FFFF);
      send_request(OP_INSERT_AT, 7'd2, $urandom);
      send_request(OP_INSERT_AT, 7'd6, $urandom);
      send_request(OP_REMOVE_AT, 7'd0, $urandom);
      send_request(OP_REMOVE_AT, 7'd6, $urandom);
      send_request(OP_REMOVE_AT, 7'd64, $urandom);
      send_request(OP_REMOVE_AT, 7'd5, $urandom);
      send_request(OP_REMOVE_AT, 7'd2, $urandom);
      send_request(OP_REMOVE_AT, 7'd1, $urandom);
      send_request(OP_POP_FRONT, 7'd0, $urandom);
      // The last remaining element must come out through the back as well.
      send_request(OP_POP_BACK, 7'd0, $urandom);
      send_request(OP_POP_BACK, 7'd0, $urandom);
   endtask

   task automatic test_random_sweep();
      for (int chunk = 0; chunk < 17; chunk++) begin
         idle_enabled = ($urandom_range(0, 3) != 0);
         repeat (100) send_random_request();
      end
      idle_enabled = 1'b1;
   endtask

   // The receiver holds off for a long stretch while beats keep coming, so
   // the output register fills and the request side has to stall.
   task automatic test_output_hold_off();
      idle_enabled = 1'b0;
      hold_request = LONG_HOLD_CYCLES;
      repeat (16) send_random_request();
      wait_for_drain();
      idle_enabled = 1'b1;
   endtask

   task automatic test_sender_pause();
      repeat (40) send_random_request();
      wait_for_drain();
      repeat (40) send_random_request();
   endtask

   task automatic test_steady_stream();
      idle_enabled = 1'b0;
      repeat (100) send_random_request();
   endtask

   // Result side: random stall bursts, plus the long hold-off on request.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every result beat is matched against the oldest outstanding prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_result.removed_value = rsp_tdata[DATA_W-1:0];
         seen_result.status = status_type'(rsp_tdata[DATA_W +: ST_W]);
         seen_result.entry_count = rsp_tdata[DATA_W+ST_W +: CNT_W];
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display({"result %0d arrived with no request outstanding: ",
                         "value %h status %s count %0d"},
                        result_index, seen_result.removed_value,
                        seen_result.status.name(), seen_result.entry_count);
         end else begin
            want_result = pending_results.pop_front();
            if (seen_result.removed_value !== want_result.removed_value
                || seen_result.status !== want_result.status
                || seen_result.entry_count !== want_result.entry_count) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"result %0d: expected value %h status %s count %0d, ",
                            "got value %h status %s count %0d"},
                           result_index, want_result.removed_value,
                           want_result.status.name(), want_result.entry_count,
                           seen_result.removed_value, seen_result.status.name(),
                           seen_result.entry_count);
            end
         end
         result_index++;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_unused_ops();
      test_positional_edges();
      test_random_sweep();
      test_output_hold_off();
      test_sender_pause();
      test_steady_stream();
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_positional_list_store: PASS");
      end else begin
         $display("tb_positional_list_store: FAIL");
      end
      $finish;
   end

endmodule

// ----- positional_list_store.f -----
+incdir+rtl/core
rtl/core/pls_pkg.sv
rtl/core/pls_datapath.sv
rtl/core/pls_ctrl.sv
rtl/core/positional_list_store.sv
sim/tb_positional_list_store.sv
